@@ hw/rtl/sparse_index_search_gather_unit_macros.svh @@
// Assertion macros for the sparse index search and gather unit.
`ifndef SPARSE_INDEX_SEARCH_GATHER_UNIT_MACROS_SVH
`define SPARSE_INDEX_SEARCH_GATHER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define SIGS_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sigs: same-cycle check failed");
// Check that cons holds in the cycle after ante.
`define SIGS_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sigs: next-cycle check failed");
`else
`define SIGS_ASSERT_NOW(name, clk, rst, ante, cons)
`define SIGS_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

@@ hw/rtl/sigs_pkg.sv @@
// Shared constants and types of the sparse index search and gather unit.
`timescale 1ns / 1ps
package sigs_pkg;
  localparam int DATA_W     = 32;
  localparam int COORD_DIMS = 8;
  localparam int DIM_IW     = 3;
  localparam int CFG_IDX_W  = 4;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 2;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISS  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  // One lane's verdict on its dimension: stored+start against the query.
  typedef struct packed {
    logic lt;
    logic gt;
  } lane_cmp_t;

  // Merged lexicographic verdict over all lanes.
  typedef struct packed {
    logic below;
    logic equal;
  } cmp_res_t;
endpackage

@@ hw/rtl/sigs_if.sv @@
// Channel interfaces: request, result and configuration write.
`timescale 1ns / 1ps
interface sigs_req_if;
  logic                               valid;
  logic                               ready;
  logic [sigs_pkg::CMD_W-1:0]  cmd;
  logic [sigs_pkg::DATA_W-1:0] coord_0;
  logic [sigs_pkg::DATA_W-1:0] coord_1;
  logic [sigs_pkg::DATA_W-1:0] coord_2;
  logic [sigs_pkg::DATA_W-1:0] coord_3;
  logic [sigs_pkg::DATA_W-1:0] coord_4;
  logic [sigs_pkg::DATA_W-1:0] coord_5;
  logic [sigs_pkg::DATA_W-1:0] coord_6;
  logic [sigs_pkg::DATA_W-1:0] coord_7;
  logic [sigs_pkg::DATA_W-1:0] grad_in;
  modport source (output valid, cmd, coord_0, coord_1, coord_2, coord_3, coord_4,
                  coord_5, coord_6, coord_7, grad_in, input ready);
  modport sink (input valid, cmd, coord_0, coord_1, coord_2, coord_3, coord_4,
                coord_5, coord_6, coord_7, grad_in, output ready);
endinterface

interface sigs_rsp_if #(parameter int POS_W = 11);
  logic                                valid;
  logic                                ready;
  logic [sigs_pkg::STATUS_W-1:0] status;
  logic [sigs_pkg::DATA_W-1:0]   grad_value;
  logic [POS_W-1:0]              match_position;
  modport source (output valid, status, grad_value, match_position, input ready);
  modport sink (input valid, status, grad_value, match_position, output ready);
endinterface

interface sigs_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [sigs_pkg::CFG_IDX_W-1:0] index;
  logic [sigs_pkg::DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/sparse_index_search_gather_unit.sv @@
// Top level of the sparse index search and gather unit.
`timescale 1ns / 1ps
`include "sparse_index_search_gather_unit_macros.svh"
// A sorted table of up to TABLE_DEPTH entries, each a coordinate of MAX_RANK
// 32-bit dimensions plus a 32-bit value. A load command appends one entry at
// the current count (dropped with status 3 when the table is full), a clear
// command empties the table, and a query command runs a lower-bound binary
// search for the first entry whose coordinate, shifted dimension by dimension
// by the start registers at 33 bits, is not below the query, then returns the
// stored value on an exact match. The table is held as one column memory per
// dimension, each with its own compare lane, so every probe reads all
// dimensions at once and the merge stage gives the lexicographic verdict.
// Sequence: load, clear and unknown commands go from transfer to S_FIN; a
// query runs S_SEARCH then S_STEP for each probe, then S_CHECK and S_FIN.
// Probes are at most the bit length of the entry count (up to 11 for a
// full table of 1024); each is a registered memory read, then a compare and
// merge. S_FIN holds the result until the output register is free. The unit
// works on one item at a time, but the result sits in an output register, so
// the next request transfers while the result waits. Configuration writes
// are always taken; start registers reset to zero.
module sparse_index_search_gather_unit #(
  parameter int TABLE_DEPTH = 1024,
  parameter int MAX_RANK    = 8
) (
  input logic        clk,
  input logic        rst,
  sigs_req_if.sink   req,
  sigs_rsp_if.source rsp,
  sigs_cfg_if.sink   cfg
);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int DW = sigs_pkg::DATA_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_STEP   = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;

  logic [2:0]    state;
  logic [DW-1:0] start [sigs_pkg::COORD_DIMS];
  logic [DW-1:0] req_coord [sigs_pkg::COORD_DIMS];
  logic [DW-1:0] query [MAX_RANK];

  logic [CW-1:0] count;
  logic [CW-1:0] base;
  logic [CW-1:0] len;
  logic [CW-1:0] half;
  logic [CW-1:0] probe;
  logic          full;
  logic          req_xfer;
  logic          rsp_xfer;
  logic          cfg_xfer;
  logic          out_free;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [DW-1:0] value_mem [TABLE_DEPTH];
  logic [DW-1:0] value_rd;

  sigs_pkg::lane_cmp_t lane_cmp [MAX_RANK];
  sigs_pkg::cmp_res_t  cmp;

  logic [sigs_pkg::STATUS_W-1:0] res_status;
  logic [DW-1:0]                 res_grad;
  logic [CW-1:0]                 res_pos;
  logic                          out_valid;
  logic [sigs_pkg::STATUS_W-1:0] out_status;
  logic [DW-1:0]                 out_grad;
  logic [CW-1:0]                 out_pos;

  assign req_coord[0] = req.coord_0;
  assign req_coord[1] = req.coord_1;
  assign req_coord[2] = req.coord_2;
  assign req_coord[3] = req.coord_3;
  assign req_coord[4] = req.coord_4;
  assign req_coord[5] = req.coord_5;
  assign req_coord[6] = req.coord_6;
  assign req_coord[7] = req.coord_7;

  // Take a new request only between items; the output register decouples rsp.
  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign req_xfer  = req.valid && req.ready;
  assign rsp_xfer  = rsp.valid && rsp.ready;
  assign cfg_xfer  = cfg.valid && cfg.ready;
  assign out_free  = !out_valid || rsp.ready;

  assign full    = (count == CW'(TABLE_DEPTH));
  assign wr_en   = req_xfer && (req.cmd == sigs_pkg::CMD_LOAD) && !full;
  assign wr_addr = count[AW-1:0];

  // Probe the middle of the live window; with an empty window, read the
  // final position back for the exact-match test.
  assign half    = len >> 1;
  assign probe   = base + half;
  assign rd_addr = (len != '0) ? probe[AW-1:0] : base[AW-1:0];

  for (genvar d = 0; d < MAX_RANK; d++) begin : g_lane
    sigs_lane #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
    ) u_lane (
      .clk     (clk),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_coord[d]),
      .rd_addr (rd_addr),
      .start   (start[d]),
      .query   (query[d]),
      .cmp     (lane_cmp[d])
    );
  end

  sigs_merge #(
    .RANK (MAX_RANK)
  ) u_merge (
    .lanes (lane_cmp),
    .res   (cmp)
  );

  // Value column: written on load, read alongside the coordinate lanes.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      value_mem[wr_addr] <= req.grad_in;
    end
    value_rd <= value_mem[rd_addr];
  end

  // Control: sequencer, table count, search window and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      base      <= '0;
      len       <= '0;
      out_valid <= 1'b0;
      for (int d = 0; d < sigs_pkg::COORD_DIMS; d++) begin
        start[d] <= '0;
      end
    end else begin
      // Writes beyond the register list are dropped.
      if (cfg_xfer && (cfg.index < sigs_pkg::CFG_IDX_W'(sigs_pkg::COORD_DIMS))) begin
        start[cfg.index[sigs_pkg::DIM_IW-1:0]] <= cfg.data;
      end
      // Drop the valid once the result transfers, unless a new one replaces it.
      if (rsp_xfer && !(state == S_FIN && out_free)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_xfer) begin
            case (req.cmd)
              sigs_pkg::CMD_LOAD: begin
                if (!full) begin
                  count <= count + CW'(1);
                end
                state <= S_FIN;
              end
              sigs_pkg::CMD_QUERY: begin
                base  <= '0;
                len   <= count;
                state <= S_SEARCH;
              end
              sigs_pkg::CMD_CLEAR: begin
                count <= '0;
                state <= S_FIN;
              end
              default: begin
                state <= S_FIN;
              end
            endcase
          end
        end
        S_SEARCH: begin
          state <= (len != '0) ? S_STEP : S_CHECK;
        end
        S_STEP: begin
          // Narrow the window on the merged verdict of the probe just read.
          if (cmp.below) begin
            base <= probe + CW'(1);
            len  <= len - half - CW'(1);
          end else begin
            len <= half;
          end
          state <= S_SEARCH;
        end
        S_CHECK: begin
          state <= S_FIN;
        end
        S_FIN: begin
          // Hold the result until the output register is free.
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload: query latch, pending result and output register.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_xfer) begin
      for (int d = 0; d < MAX_RANK; d++) begin
        query[d] <= req_coord[d];
      end
      res_grad <= '0;
      case (req.cmd)
        sigs_pkg::CMD_LOAD: begin
          res_status <= full ? sigs_pkg::ST_FULL : sigs_pkg::ST_DONE;
          res_pos    <= count;
        end
        sigs_pkg::CMD_CLEAR: begin
          res_status <= sigs_pkg::ST_DONE;
          res_pos    <= '0;
        end
        default: begin
          res_status <= sigs_pkg::ST_DONE;
          res_pos    <= count;
        end
      endcase
    end
    if (state == S_CHECK) begin
      res_pos <= base;
      if ((base < count) && cmp.equal) begin
        res_status <= sigs_pkg::ST_FOUND;
        res_grad   <= value_rd;
      end else begin
        res_status <= sigs_pkg::ST_MISS;
        res_grad   <= '0;
      end
    end
    if (state == S_FIN && out_free) begin
      out_status <= res_status;
      out_grad   <= res_grad;
      out_pos    <= res_pos;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.grad_value     = out_grad;
  assign rsp.match_position = out_pos;

  `SIGS_ASSERT_NOW(a_step_live_window, clk, rst, state == S_STEP, len != '0)
  `SIGS_ASSERT_NOW(a_check_in_range, clk, rst, state == S_CHECK, base <= count)
  `SIGS_ASSERT_NEXT(a_full_load_drop, clk, rst,
                    req_xfer && (req.cmd == sigs_pkg::CMD_LOAD) && full, count == $past(count))
endmodule

@@ hw/rtl/sigs_lane.sv @@
// One coordinate lane: column store for a dimension and its shifted compare.
`timescale 1ns / 1ps
module sigs_lane #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [sigs_pkg::DATA_W-1:0] wr_data,
  input  logic [AW-1:0]               rd_addr,
  input  logic [sigs_pkg::DATA_W-1:0] start,
  input  logic [sigs_pkg::DATA_W-1:0] query,
  output sigs_pkg::lane_cmp_t         cmp
);
  logic [sigs_pkg::DATA_W-1:0] mem [DEPTH];
  logic [sigs_pkg::DATA_W-1:0] rd_data;
  logic [sigs_pkg::DATA_W:0]   shifted;
  logic [sigs_pkg::DATA_W:0]   target;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // 33-bit sum, so a carry out of the stored word never wraps
  assign shifted = {1'b0, rd_data} + {1'b0, start};
  assign target  = {1'b0, query};
  assign cmp.lt  = shifted < target;
  assign cmp.gt  = shifted > target;
endmodule

@@ hw/rtl/sigs_merge.sv @@
// Merge of lane verdicts into one lexicographic order, dimension 0 first.
`timescale 1ns / 1ps
module sigs_merge #(
  parameter int RANK = 8
) (
  input  sigs_pkg::lane_cmp_t lanes [RANK],
  output sigs_pkg::cmp_res_t  res
);
  logic decided;
  logic below;

  always_comb begin
    decided = 1'b0;
    below   = 1'b0;
    for (int d = 0; d < RANK; d++) begin
      if (!decided && (lanes[d].lt || lanes[d].gt)) begin
        below   = lanes[d].lt;
        decided = 1'b1;
      end
    end
    res.below = below;
    res.equal = !decided;
  end
endmodule

@@ sim/sparse_index_search_gather_unit_checker.sv @@
// Scoreboard for the sparse index search and gather unit: predicts and compares results.
`timescale 1ns / 1ps
module sparse_index_search_gather_unit_checker #(
  parameter int TABLE_DEPTH = 1024,
  parameter int MAX_RANK    = 8,
  parameter int POS_W       = 11
) (
  input  logic        clk,
  input  logic        rst,
  sigs_req_if         req,
  sigs_rsp_if         rsp,
  sigs_cfg_if         cfg,
  output int unsigned fail_count,
  output int unsigned pending
);
  localparam int MAX_REPORTS = 10;
  localparam int DW          = sigs_pkg::DATA_W;
  localparam int NDIM        = sigs_pkg::COORD_DIMS;

  typedef logic [NDIM-1:0][DW-1:0] coord_t;

  typedef struct packed {
    logic [sigs_pkg::STATUS_W-1:0] status;
    logic [DW-1:0]                 grad_value;
    logic [POS_W-1:0]              match_position;
  } gather_res_t;

  logic [DW-1:0] slice_start [NDIM];
  coord_t        coord_mem [TABLE_DEPTH];
  logic [DW-1:0] grad_mem [TABLE_DEPTH];
  int unsigned   fill;
  gather_res_t   expected_q [$];
  int unsigned   mismatches;
  int unsigned   result_no;

  // -1 when the shifted entry sorts below the key, 0 when equal, +1 when above.
  // Sums are taken at 33 bits so a large start never wraps round.
  function automatic int order_vs_key(input int unsigned slot, input coord_t key);
    logic [DW:0] shifted;
    for (int d = 0; d < MAX_RANK; d++) begin
      shifted = {1'b0, coord_mem[slot][d]} + {1'b0, slice_start[d]};
      if (shifted < {1'b0, key[d]}) return -1;
      if (shifted > {1'b0, key[d]}) return 1;
    end
    return 0;
  endfunction

  // Fixed probe sequence, so an unsorted table lands where the hardware does.
  function automatic int unsigned first_not_below(input coord_t key);
    int unsigned base, span, half;
    base = 0;
    span = fill;
    while (span > 0) begin
      half = span / 2;
      if (order_vs_key(base + half, key) < 0) begin
        base += half + 1;
        span -= half + 1;
      end else begin
        span = half;
      end
    end
    return base;
  endfunction

  function automatic gather_res_t apply_item(input logic [sigs_pkg::CMD_W-1:0] cmd,
                                             input coord_t key, input logic [DW-1:0] grad);
    gather_res_t res;
    int unsigned lb;
    res = '{status: sigs_pkg::ST_DONE, grad_value: '0, match_position: POS_W'(fill)};
    case (cmd)
      sigs_pkg::CMD_LOAD: begin
        if (fill < TABLE_DEPTH) begin
          coord_mem[fill] = key;
          grad_mem[fill]  = grad;
          fill++;
        end else begin
          res.status = sigs_pkg::ST_FULL;
        end
      end
      sigs_pkg::CMD_QUERY: begin
        lb = first_not_below(key);
        res.match_position = POS_W'(lb);
        if (lb < fill && order_vs_key(lb, key) == 0) begin
          res.status     = sigs_pkg::ST_FOUND;
          res.grad_value = grad_mem[lb];
        end else begin
          res.status = sigs_pkg::ST_MISS;
        end
      end
      sigs_pkg::CMD_CLEAR: begin
        fill = 0;
        res.match_position = '0;
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : watch
    gather_res_t want, got;
    coord_t      key;
    if (rst) begin
      fill = 0;
      foreach (slice_start[d]) slice_start[d] = '0;
      expected_q.delete();
    end else begin
      // Retire the oldest expectation first: a request in this cycle is younger.
      if (rsp.valid && rsp.ready) begin
        result_no++;
        got = '{rsp.status, rsp.grad_value, rsp.match_position};
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("[%0t] result %0d with nothing outstanding: status %0d grad %h pos %0d",
                     $realtime, result_no, got.status, got.grad_value, got.match_position);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("[%0t] result %0d: expected status %0d grad %h pos %0d, got %0d %h %0d",
                       $realtime, result_no, want.status, want.grad_value,
                       want.match_position, got.status, got.grad_value, got.match_position);
          end
        end
      end
      if (cfg.valid && cfg.ready && cfg.index < NDIM)
        slice_start[cfg.index] = cfg.data;
      if (req.valid && req.ready) begin
        key = {req.coord_7, req.coord_6, req.coord_5, req.coord_4,
               req.coord_3, req.coord_2, req.coord_1, req.coord_0};
        expected_q.push_back(apply_item(req.cmd, key, req.grad_in));
      end
    end
    fail_count <= mismatches;
    pending    <= expected_q.size();
  end
endmodule

@@ sim/sparse_index_search_gather_unit_tb.sv @@
// Testbench top for the sparse index search and gather unit: stimulus and verdict.
`timescale 1ns / 1ps
module sparse_index_search_gather_unit_tb;
  localparam int TABLE_DEPTH = 1024;
  localparam int MAX_RANK    = 8;
  localparam int POS_W       = 11;
  localparam int DW          = sigs_pkg::DATA_W;
  localparam int NDIM        = sigs_pkg::COORD_DIMS;
  localparam int CMDW        = sigs_pkg::CMD_W;

  // Command code outside the defined set; the unit must leave its state alone.
  localparam logic [CMDW-1:0] CMD_UNKNOWN = 2'd3;

  localparam logic [DW-1:0] ALL_ONES = '1;

  localparam int IDLE_PCT          = 38;
  // Quiet-cycle limit: many times a full-table query, plus stalls.
  localparam int STALL_LIMIT       = 5000;
  localparam int SETTLE_CYCLES     = 40;
  localparam int SMALL_PHASE_ITEMS = 100;
  localparam int QUERY_SPACING     = 24;

  typedef logic [NDIM-1:0][DW-1:0] coord_t;

  // How the start registers are set for a phase.
  typedef enum int {
    OFS_ZERO,
    OFS_ONES,
    OFS_SMALL,
    OFS_WIDE,
    OFS_MIXED
  } start_plan_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  bit          steady;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned quiet_cycles;
  int unsigned item_count;

  // Stimulus bookkeeping: what has been loaded, and the starts in force.
  coord_t        loaded [TABLE_DEPTH];
  int unsigned   n_loaded;
  logic [DW-1:0] start_val [NDIM];
  logic [DW-1:0] headroom [NDIM];
  int unsigned   rank;

  sigs_req_if                  req_ch ();
  sigs_rsp_if #(.POS_W(POS_W)) rsp_ch ();
  sigs_cfg_if                  cfg_ch ();

  sparse_index_search_gather_unit #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .MAX_RANK   (MAX_RANK)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  sparse_index_search_gather_unit_checker #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .MAX_RANK   (MAX_RANK),
    .POS_W      (POS_W)
  ) i_checker (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg       (cfg_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Decide whether a side sits out this cycle; never while the steady stretch runs.
  function automatic bit take_gap();
    return !steady && ($urandom_range(0, 99) < IDLE_PCT);
  endfunction

  // Result side: drop ready at random, updated on the falling edge.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ch.ready <= !take_gap();
    end
  end

  // Watchdog: count cycles with no transfer on any channel.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request and hold it until the transfer. Called and returns on a
  // falling edge with valid still high, so a back-to-back item never drops it.
  task automatic send_item(input logic [CMDW-1:0] cmd, input coord_t key,
                           input logic [DW-1:0] grad);
    while (take_gap()) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.cmd     <= cmd;
    req_ch.coord_0 <= key[0];
    req_ch.coord_1 <= key[1];
    req_ch.coord_2 <= key[2];
    req_ch.coord_3 <= key[3];
    req_ch.coord_4 <= key[4];
    req_ch.coord_5 <= key[5];
    req_ch.coord_6 <= key[6];
    req_ch.coord_7 <= key[7];
    req_ch.grad_in <= grad;
    do begin
      @(posedge clk);
    end while (!req_ch.ready);
    @(negedge clk);
    // Track the table so that queries can aim at real entries.
    if (cmd == sigs_pkg::CMD_LOAD && n_loaded < TABLE_DEPTH) begin
      loaded[n_loaded] = key;
      n_loaded++;
    end else if (cmd == sigs_pkg::CMD_CLEAR) begin
      n_loaded = 0;
    end
    if (cmd != CMD_UNKNOWN) item_count++;
  endtask

  task automatic cfg_write(input int idx, input logic [DW-1:0] val);
    while (take_gap()) begin
      cfg_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx[sigs_pkg::CFG_IDX_W-1:0];
    cfg_ch.data  <= val;
    do begin
      @(posedge clk);
    end while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  // Drop the request, wait for every outstanding result, then let the
  // pipeline go quiet.
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write all eight start registers. Only call once the unit has settled.
  task automatic program_starts(input start_plan_t plan);
    logic [DW-1:0] val;
    for (int d = 0; d < NDIM; d++) begin
      case (plan)
        OFS_ZERO:  val = '0;
        OFS_ONES:  val = ALL_ONES;
        OFS_SMALL: val = $urandom_range(0, 15);
        OFS_WIDE:  val = $urandom();
        default:   val = ($urandom_range(0, 2) == 0) ? ALL_ONES : $urandom_range(0, 255);
      endcase
      cfg_write(d, val);
      start_val[d] = val;
      headroom[d]  = ~val;
    end
    // Hit an index past the last start register now and then; it must change nothing.
    if ($urandom_range(0, 3) == 0) cfg_write(NDIM + $urandom_range(0, 7), $urandom());
    cfg_ch.valid <= 1'b0;
  endtask

  // Random coordinate over the active rank, or over every dimension for noise.
  function automatic coord_t random_key(input bit all_dims);
    coord_t key;
    key = '0;
    for (int d = 0; d < NDIM; d++)
      if (all_dims || d < rank) key[d] = $urandom();
    return key;
  endfunction

  // Next entry of an ascending sequence. Stored values stay within the headroom
  // left by the starts, so every entry stays reachable by an exact query.
  function automatic coord_t next_sorted(input logic [DW-1:0] step);
    coord_t        key;
    int            d;
    logic [DW-1:0] span;
    key = '0;
    if (n_loaded == 0) begin
      for (int e = 0; e < rank; e++)
        key[e] = $urandom_range(0, (e == 0) ? headroom[0] >> 1 : headroom[e]);
      return key;
    end
    key = loaded[n_loaded - 1];
    // Repeat the last entry sometimes; lower bound must then land on the first copy.
    if ($urandom_range(0, 9) == 0) return key;
    d = $urandom_range(0, rank - 1);
    while (d >= 0 && key[d] >= headroom[d]) d--;
    if (d < 0) return key;
    span   = headroom[d] - key[d];
    key[d] = key[d] + $urandom_range(1, (span < step) ? span : step);
    for (int e = d + 1; e < rank; e++) key[e] = $urandom_range(0, headroom[e]);
    return key;
  endfunction

  // Mostly aim at a loaded entry (shifted by the starts), sometimes just off it.
  function automatic coord_t pick_query();
    coord_t      q;
    int unsigned slot;
    int unsigned d;
    if (n_loaded == 0 || $urandom_range(0, 9) < 2) return random_key($urandom_range(0, 3) == 0);
    slot = $urandom_range(0, n_loaded - 1);
    for (int e = 0; e < NDIM; e++) q[e] = loaded[slot][e] + start_val[e];
    if ($urandom_range(0, 9) < 4) begin
      d    = $urandom_range(0, rank - 1);
      q[d] = $urandom_range(0, 1) ? q[d] + 1 : q[d] - 1;
    end
    return q;
  endfunction

  // One phase: new starts, empty table, a fill, then a mix led by queries.
  task automatic run_phase(input start_plan_t plan, input int unsigned entries,
                           input int unsigned mixed, input bit ordered,
                           input logic [DW-1:0] step);
    int unsigned pick;
    settle();
    program_starts(plan);
    rank = $urandom_range(1, MAX_RANK);
    send_item(sigs_pkg::CMD_CLEAR, random_key(1'b1), $urandom());
    for (int i = 0; i < entries; i++)
      send_item(sigs_pkg::CMD_LOAD, ordered ? next_sorted(step) : random_key(1'b0), $urandom());
    for (int i = 0; i < mixed; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 75)
        send_item(sigs_pkg::CMD_QUERY, pick_query(), $urandom());
      else if (pick < 85)
        send_item(CMD_UNKNOWN, random_key(1'b1), $urandom());
      else if (pick < 95)
        send_item(sigs_pkg::CMD_LOAD, ordered ? next_sorted(step) : random_key(1'b0),
                  $urandom());
      else
        send_item(sigs_pkg::CMD_CLEAR, random_key(1'b1), $urandom());
    end
  endtask

  initial begin : stimulus
    coord_t k;

    // Hold every input at a known value from the first instant.
    req_ch.valid   = 1'b0;
    req_ch.cmd     = sigs_pkg::CMD_LOAD;
    req_ch.coord_0 = '0;
    req_ch.coord_1 = '0;
    req_ch.coord_2 = '0;
    req_ch.coord_3 = '0;
    req_ch.coord_4 = '0;
    req_ch.coord_5 = '0;
    req_ch.coord_6 = '0;
    req_ch.coord_7 = '0;
    req_ch.grad_in = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = '0;
    cfg_ch.data    = '0;
    rank           = MAX_RANK;
    foreach (start_val[d]) begin
      start_val[d] = '0;
      headroom[d]  = ALL_ONES;
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: starts at their reset value of zero.
    // Query before anything is loaded: miss at position zero.
    send_item(sigs_pkg::CMD_QUERY, '0, ALL_ONES);
    // Four ascending entries spanning the coordinate range.
    send_item(sigs_pkg::CMD_LOAD, '0, '0);
    k = '0;
    k[NDIM-1] = 32'd1;
    send_item(sigs_pkg::CMD_LOAD, k, ALL_ONES);
    k = {NDIM{32'h5555_5555}};
    k[0] = 32'h8000_0000;
    send_item(sigs_pkg::CMD_LOAD, k, 32'h1234_5678);
    send_item(sigs_pkg::CMD_LOAD, {NDIM{ALL_ONES}}, 32'hA5A5_A5A5);
    // Hits at first and last entry, a miss between two entries, a miss on a low dimension.
    send_item(sigs_pkg::CMD_QUERY, '0, '0);
    k = '0;
    k[NDIM-1] = 32'd1;
    send_item(sigs_pkg::CMD_QUERY, k, '0);
    k[NDIM-1] = 32'd2;
    send_item(sigs_pkg::CMD_QUERY, k, '0);
    k = {NDIM{32'hAAAA_AAAA}};
    k[0] = 32'h8000_0000;
    send_item(sigs_pkg::CMD_QUERY, k, '0);
    send_item(sigs_pkg::CMD_QUERY, {NDIM{ALL_ONES}}, '0);
    // Unknown command: nothing changes, position reports the count.
    send_item(CMD_UNKNOWN, {NDIM{ALL_ONES}}, ALL_ONES);
    // Clear, then query the now empty table.
    send_item(sigs_pkg::CMD_CLEAR, {NDIM{32'h5A5A_5A5A}}, '0);
    send_item(sigs_pkg::CMD_QUERY, {NDIM{ALL_ONES}}, '0);
    // Out of order table: the search still runs its fixed probes.
    send_item(sigs_pkg::CMD_LOAD, {NDIM{ALL_ONES}}, 32'h0F0F_0F0F);
    send_item(sigs_pkg::CMD_LOAD, '0, 32'hF0F0_F0F0);
    send_item(sigs_pkg::CMD_QUERY, '0, '0);
    send_item(sigs_pkg::CMD_QUERY, {NDIM{ALL_ONES}}, '0);

    // Maximum starts: the 33-bit sum must not wrap, so nothing can match.
    settle();
    program_starts(OFS_ONES);
    send_item(sigs_pkg::CMD_CLEAR, '0, '0);
    send_item(sigs_pkg::CMD_LOAD, {NDIM{ALL_ONES}}, ALL_ONES);
    send_item(sigs_pkg::CMD_QUERY, {NDIM{ALL_ONES}}, '0);
    send_item(sigs_pkg::CMD_QUERY, '0, '0);

    // Random: small tables first, most of them sorted, starting with zero starts.
    run_phase(OFS_ZERO, $urandom_range(1, 40), $urandom_range(15, 35), 1'b1, 3);
    while (item_count < SMALL_PHASE_ITEMS)
      run_phase(start_plan_t'($urandom_range(0, 4)), $urandom_range(0, 40),
                $urandom_range(15, 35), $urandom_range(0, 4) != 0,
                $urandom_range(0, 1) ? 32'd3 : ALL_ONES);

    // Fill the table to the brim with queries along the way, run a steady
    // stretch part way through, then push loads into the full table.
    settle();
    program_starts(OFS_SMALL);
    rank = $urandom_range(1, MAX_RANK);
    send_item(sigs_pkg::CMD_CLEAR, random_key(1'b1), $urandom());
    for (int i = 0; i < TABLE_DEPTH + 3; i++) begin
      steady = (i >= 200 && i < 520);
      send_item(sigs_pkg::CMD_LOAD, next_sorted(3), $urandom());
      if (i % QUERY_SPACING == QUERY_SPACING - 1)
        send_item(sigs_pkg::CMD_QUERY, pick_query(), $urandom());
    end
    steady = 1'b0;
    for (int i = 0; i < 40; i++)
      send_item(sigs_pkg::CMD_QUERY, pick_query(), $urandom());
    send_item(CMD_UNKNOWN, random_key(1'b1), $urandom());
    send_item(sigs_pkg::CMD_LOAD, next_sorted(3), $urandom());
    send_item(sigs_pkg::CMD_CLEAR, random_key(1'b1), $urandom());
    send_item(sigs_pkg::CMD_QUERY, pick_query(), $urandom());

    // Drain every outstanding result before the verdict.
    settle();
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule

@@ sparse_index_search_gather_unit.f @@
+incdir+hw/rtl
hw/rtl/sigs_pkg.sv
hw/rtl/sigs_if.sv
hw/rtl/sigs_lane.sv
hw/rtl/sigs_merge.sv
hw/rtl/sparse_index_search_gather_unit.sv
sim/sparse_index_search_gather_unit_checker.sv
sim/sparse_index_search_gather_unit_tb.sv
